FILE: hw/rtl/bee_pkg.sv
// Package for the block entropy encoder: payload types, symbol and status codes,
// fixed DC and AC Huffman tables and the magnitude category function.
// No dependencies; the value coder, the result buffer and the top level import it.
package bee_pkg;

    localparam int COEF_W  = 12;
    localparam int CODE_W  = 26;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 6;
    localparam int RUN_W   = 5;
    localparam int CAT_W   = 4;
    localparam int PRE_W   = 16;
    localparam int NUM_COMP = 3;
    localparam int MAX_RESULTS = 3;

    localparam logic [1:0] KIND_DC  = 2'd0;
    localparam logic [1:0] KIND_AC  = 2'd1;
    localparam logic [1:0] KIND_ZRL = 2'd2;
    localparam logic [1:0] KIND_EOB = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_NO_CODE = 2'd2;

    localparam logic [POS_W-1:0] LAST_POS  = 6'd63;
    localparam logic [RUN_W-1:0] ZRL_COUNT = 5'd16;
    localparam logic [CAT_W-1:0] DC_MAX_CAT = 4'd11;
    localparam logic [CAT_W-1:0] AC_MAX_CAT = 4'd10;

    localparam logic [PRE_W-1:0] ZRL_CODE = 16'h07F9;
    localparam logic [LEN_W-1:0] ZRL_LEN  = 5'd11;
    localparam logic [PRE_W-1:0] EOB_CODE = 16'h000A;
    localparam logic [LEN_W-1:0] EOB_LEN  = 5'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [1:0]               component;
        logic                     new_image;
    } bee_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [1:0]        symbol_kind;
        logic [1:0]        status;
        logic              last_of_item;
    } bee_out_t;

    typedef struct packed {
        logic [PRE_W-1:0] code;
        logic [LEN_W-1:0] len;
    } code_entry_t;

    // Handshake between the coding stage and the result buffer.
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } bee_load_t;

    function automatic logic [CAT_W-1:0] bee_category(input logic [COEF_W-1:0] mag);
        logic [CAT_W-1:0] cat;
        cat = '0;
        for (int i = 0; i < COEF_W; i++) begin
            if (mag[i])
            begin
                cat = CAT_W'(i + 1);
            end
        end
        return cat;
    endfunction

    function automatic code_entry_t bee_dc_code(input logic [CAT_W-1:0] cat);
        code_entry_t e;
        e = '{16'h0000, 5'd0};
        case (cat)
            4'd0:    e = '{16'h0002, 5'd3};
            4'd1:    e = '{16'h0003, 5'd3};
            4'd2:    e = '{16'h0004, 5'd3};
            4'd3:    e = '{16'h0000, 5'd2};
            4'd4:    e = '{16'h0005, 5'd3};
            4'd5:    e = '{16'h0006, 5'd3};
            4'd6:    e = '{16'h000E, 5'd4};
            4'd7:    e = '{16'h001E, 5'd5};
            4'd8:    e = '{16'h003E, 5'd6};
            4'd9:    e = '{16'h007E, 5'd7};
            4'd10:   e = '{16'h00FE, 5'd8};
            4'd11:   e = '{16'h01FE, 5'd9};
            default: e = '{16'h0000, 5'd0};
        endcase
        return e;
    endfunction

    // Run/size table; an absent entry has length zero.
    function automatic code_entry_t bee_ac_code(input logic [3:0] run,
                                                input logic [CAT_W-1:0] cat);
        code_entry_t e;
        e = '{16'h0000, 5'd0};
        case ({run, cat})
            8'h00: e = '{16'h000A, 5'd4};
            8'h01: e = '{16'h0000, 5'd2};
            8'h02: e = '{16'h0001, 5'd2};
            8'h03: e = '{16'h0004, 5'd3};
            8'h04: e = '{16'h000B, 5'd4};
            8'h05: e = '{16'h001A, 5'd5};
            8'h06: e = '{16'h0038, 5'd6};
            8'h07: e = '{16'h0078, 5'd7};
            8'h08: e = '{16'h01F6, 5'd9};
            8'h09: e = '{16'h07F6, 5'd11};
            8'h0A: e = '{16'hFF83, 5'd16};
            8'h11: e = '{16'h000C, 5'd4};
            8'h12: e = '{16'h001B, 5'd5};
            8'h13: e = '{16'h0079, 5'd7};
            8'h14: e = '{16'h00F8, 5'd8};
            8'h15: e = '{16'h03F3, 5'd10};
            8'h16: e = '{16'h0FF5, 5'd12};
            8'h17: e = '{16'hFF84, 5'd16};
            8'h18: e = '{16'hFF85, 5'd16};
            8'h19: e = '{16'hFF86, 5'd16};
            8'h21: e = '{16'h003A, 5'd6};
            8'h22: e = '{16'h00FA, 5'd8};
            8'h23: e = '{16'h03F7, 5'd10};
            8'h24: e = '{16'h0FF6, 5'd12};
            8'h25: e = '{16'hFF87, 5'd16};
            8'h26: e = '{16'hFF88, 5'd16};
            8'h27: e = '{16'hFF89, 5'd16};
            8'h31: e = '{16'h003B, 5'd6};
            8'h32: e = '{16'h00FB, 5'd8};
            8'h33: e = '{16'h07F8, 5'd11};
            8'h34: e = '{16'hFF8A, 5'd16};
            8'h35: e = '{16'hFF8B, 5'd16};
            8'h36: e = '{16'hFF8C, 5'd16};
            8'h41: e = '{16'h007A, 5'd7};
            8'h42: e = '{16'h01FA, 5'd9};
            8'h43: e = '{16'h0FF7, 5'd12};
            8'h44: e = '{16'hFF8D, 5'd16};
            8'h45: e = '{16'hFF8E, 5'd16};
            8'h51: e = '{16'h007B, 5'd7};
            8'h52: e = '{16'h03FA, 5'd10};
            8'h53: e = '{16'hFF90, 5'd16};
            8'h54: e = '{16'hFF91, 5'd16};
            8'h61: e = '{16'h00F9, 5'd8};
            8'h62: e = '{16'h03FB, 5'd10};
            8'h63: e = '{16'hFF92, 5'd16};
            8'h71: e = '{16'h00FB, 5'd8};
            8'h72: e = '{16'h0FF4, 5'd12};
            8'h73: e = '{16'hFF93, 5'd16};
            8'h81: e = '{16'h01F8, 5'd9};
            8'h82: e = '{16'hFF94, 5'd16};
            8'h91: e = '{16'h03F2, 5'd10};
            8'h92: e = '{16'hFF95, 5'd16};
            8'hA1: e = '{16'h03F4, 5'd10};
            8'hA2: e = '{16'hFF96, 5'd16};
            8'hB1: e = '{16'h03F5, 5'd10};
            8'hB2: e = '{16'hFF97, 5'd16};
            8'hC1: e = '{16'h03F6, 5'd10};
            8'hC2: e = '{16'hFF98, 5'd16};
            8'hD1: e = '{16'h03F8, 5'd10};
            8'hD2: e = '{16'hFF99, 5'd16};
            8'hE1: e = '{16'h03F9, 5'd10};
            8'hE2: e = '{16'hFF9A, 5'd16};
            8'hF0: e = '{16'h07F9, 5'd11};
            default: e = '{16'h0000, 5'd0};
        endcase
        return e;
    endfunction

endpackage

FILE: hw/rtl/bee_stream_if.sv
// Valid/ready stream interface used for both coefficient and code channels.
// Payload type comes from bee_pkg at the point of instantiation.
interface bee_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/bee_value_coder.sv
// Codes one value as Huffman prefix plus one's-complement mantissa.
// Depends on bee_pkg for the tables and the category function.
module bee_value_coder
    import bee_pkg::*;
(
    input  logic signed [COEF_W:0] value,
    input  logic [3:0]             run,
    input  logic                   is_dc,
    output logic [CODE_W-1:0]      code_bits,
    output logic [LEN_W-1:0]       code_length,
    output logic [1:0]             status
);

    logic [COEF_W:0]   mag_full;
    logic [COEF_W-1:0] mag;
    logic [COEF_W-1:0] mask;
    logic [COEF_W-1:0] mant;
    logic [CAT_W-1:0]  cat;
    logic [CAT_W-1:0]  max_cat;
    code_entry_t       entry;

    always_comb
    begin
        mag_full = value[COEF_W] ? (COEF_W+1)'(-value) : value;
        mag      = mag_full[COEF_W-1:0];
        cat      = bee_category(mag);
        max_cat  = is_dc ? DC_MAX_CAT : AC_MAX_CAT;
        entry    = is_dc ? bee_dc_code(cat) : bee_ac_code(run, cat);
        mask     = (COEF_W'(1) << cat) - COEF_W'(1);
        mant     = value[COEF_W] ? (mask - mag) : mag;

        code_bits   = '0;
        code_length = '0;
        status      = STATUS_OK;
        if (cat > max_cat)
        begin
            status = STATUS_RANGE;
        end
        else if (entry.len == '0)
        begin
            status = STATUS_NO_CODE;
        end
        else
        begin
            code_bits   = (CODE_W'(entry.code) << cat) | CODE_W'(mant);
            code_length = entry.len + LEN_W'(cat);
        end
    end

endmodule

FILE: hw/rtl/bee_result_buf.sv
// Holds up to three codes of one coefficient; drains one per cycle while ready.
// Depends on bee_pkg and bee_stream_if.
module bee_result_buf
    import bee_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bee_load_t             load,
    input  bee_out_t              load_slot [MAX_RESULTS],
    output logic                  load_ok,
    bee_stream_if.source          code_stream
);

    bee_out_t   slot_reg [MAX_RESULTS];
    logic [1:0] count_reg;
    logic       out_fire;

    assign out_fire = (count_reg != 2'd0) && code_stream.ready;
    assign load_ok  = (count_reg == 2'd0) || ((count_reg == 2'd1) && code_stream.ready);

    assign code_stream.valid   = count_reg != 2'd0;
    assign code_stream.payload = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load.valid && load_ok)
        begin
            count_reg <= load.count;
        end
        else if (out_fire)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Payload slots: load a fresh set or shift toward the output.
    always_ff @(posedge clk)
    begin
        if (load.valid && load_ok)
        begin
            slot_reg <= load_slot;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

FILE: hw/rtl/block_entropy_encoder.sv
// Top level of the block entropy encoder: input register, coding stage, result buffer.
// Depends on bee_pkg, bee_stream_if, bee_value_coder and bee_result_buf.
//
// Takes quantized coefficients in zigzag order, 64 per block, and emits Huffman
// codes (prefix then mantissa, right aligned) one code per transfer on
// code_stream. Position 0 of a block is coded as a DC difference against the
// component's predictor; positions 1 to 63 produce run/size codes, ZRL after
// sixteen zeros and EOB after position 63. A coefficient transfer is captured in
// an input register, coded combinationally against the stored predictors and
// counters, and its codes (zero to three) land in a three-entry result buffer,
// so the first code is offered once the coefficient has passed the input register
// and been loaded into the buffer. The buffer has a single output port, so the
// block takes one coefficient per cycle while each produces at most one code and
// code_stream is ready, and stalls while the buffer drains the extra codes of a
// ZRL or EOB. A coefficient is taken while the buffer still presents its last
// code. Codes with status other than ok carry length zero. No clearing pass:
// all state is ready right after reset.
module block_entropy_encoder
    import bee_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bee_stream_if.sink    coeff_stream,
    bee_stream_if.source  code_stream
);

    // Input register
    logic    s1_valid_reg;
    bee_in_t s1_item_reg;
    logic    advance;
    logic    load_ok;

    // Stored coding state
    logic [COEF_W-1:0] pred_reg [NUM_COMP];
    logic [COEF_W-1:0] pred_next [NUM_COMP];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [RUN_W-1:0]  zrun_reg;
    logic [RUN_W-1:0]  zrun_next;

    // Coding stage
    logic [POS_W-1:0]         pos_eff;
    logic [RUN_W-1:0]         zrun_eff;
    logic [COEF_W-1:0]        pred_sel;
    logic signed [COEF_W:0]   dc_diff;
    logic signed [COEF_W:0]   coder_value;
    logic [3:0]               coder_run;
    logic                     is_dc;
    logic                     zrl_hit;
    logic                     ac_hit;
    logic                     eob_hit;
    logic [CODE_W-1:0]        coder_bits;
    logic [LEN_W-1:0]         coder_length;
    logic [1:0]               coder_status;
    logic [MAX_RESULTS-1:0]   cand_hit;
    bee_out_t                 cand [MAX_RESULTS];
    bee_out_t                 load_slot [MAX_RESULTS];
    logic [1:0]               slot_idx;
    bee_load_t                load;

    // Hold the item while the buffer is busy; take a new one as the old one leaves.
    assign advance            = s1_valid_reg && load_ok;
    assign coeff_stream.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (coeff_stream.ready)
        begin
            s1_valid_reg <= coeff_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coeff_stream.valid && coeff_stream.ready)
        begin
            s1_item_reg <= coeff_stream.payload;
        end
    end

    // A new image clears predictors, position and zero run before this item.
    always_comb
    begin
        pos_eff  = s1_item_reg.new_image ? '0 : pos_reg;
        zrun_eff = s1_item_reg.new_image ? '0 : zrun_reg;
        pred_sel = '0;
        if (!s1_item_reg.new_image)
        begin
            case (s1_item_reg.component)
                2'd0:    pred_sel = pred_reg[0];
                2'd1:    pred_sel = pred_reg[1];
                2'd2:    pred_sel = pred_reg[2];
                default: pred_sel = '0;
            endcase
        end

        is_dc   = pos_eff == '0;
        zrl_hit = !is_dc && (zrun_eff == ZRL_COUNT);
        ac_hit  = !is_dc && (s1_item_reg.coefficient != '0);
        eob_hit = !is_dc && (pos_eff == LAST_POS);

        dc_diff = {s1_item_reg.coefficient[COEF_W-1], s1_item_reg.coefficient}
                - $signed({pred_sel[COEF_W-1], pred_sel});
        coder_value = is_dc ? dc_diff
                            : {s1_item_reg.coefficient[COEF_W-1], s1_item_reg.coefficient};
        // A ZRL in the same item restarts the run from zero.
        coder_run = zrl_hit ? 4'd0 : zrun_eff[3:0];
    end

    bee_value_coder u_value_coder (
        .value       (coder_value),
        .run         (coder_run),
        .is_dc       (is_dc),
        .code_bits   (coder_bits),
        .code_length (coder_length),
        .status      (coder_status)
    );

    // Gather the codes of this item in order ZRL, value, EOB; mark the last one.
    always_comb
    begin
        cand[0] = '{CODE_W'(ZRL_CODE), ZRL_LEN, KIND_ZRL, STATUS_OK, 1'b0};
        cand[1] = '{coder_bits, coder_length, is_dc ? KIND_DC : KIND_AC, coder_status, 1'b0};
        cand[2] = '{CODE_W'(EOB_CODE), EOB_LEN, KIND_EOB, STATUS_OK, 1'b0};
        cand_hit = {eob_hit, is_dc || ac_hit, zrl_hit};

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            load_slot[i] = '0;
        end
        slot_idx = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (cand_hit[i])
            begin
                load_slot[slot_idx] = cand[i];
                slot_idx = slot_idx + 2'd1;
            end
        end
        if (slot_idx != 2'd0)
        begin
            load_slot[slot_idx - 2'd1].last_of_item = 1'b1;
        end

        load.valid = s1_valid_reg;
        load.count = slot_idx;
    end

    bee_result_buf u_result_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .load_slot   (load_slot),
        .load_ok     (load_ok),
        .code_stream (code_stream)
    );

    // Next coding state
    always_comb
    begin
        for (int k = 0; k < NUM_COMP; k++)
        begin
            pred_next[k] = s1_item_reg.new_image ? '0 : pred_reg[k];
            if (is_dc && (s1_item_reg.component == 2'(k)))
            begin
                pred_next[k] = s1_item_reg.coefficient;
            end
        end

        if (is_dc || ac_hit || eob_hit)
        begin
            zrun_next = '0;
        end
        else
        begin
            zrun_next = (zrl_hit ? RUN_W'(0) : zrun_eff) + RUN_W'(1);
        end

        pos_next = pos_eff + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COMP; k++)
            begin
                pred_reg[k] <= '0;
            end
            pos_reg  <= '0;
            zrun_reg <= '0;
        end
        else if (advance)
        begin
            pred_reg <= pred_next;
            pos_reg  <= pos_next;
            zrun_reg <= zrun_next;
        end
    end

`ifndef SYNTHESIS
    // A block that ends leaves position and zero run cleared.
    a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && eob_hit |=> (pos_reg == '0) && (zrun_reg == '0))
        else $error("position or zero run not cleared after end of block");

    // An error code never carries bits.
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        code_stream.valid && (code_stream.payload.status != STATUS_OK)
        |-> (code_stream.payload.code_length == '0) && (code_stream.payload.code_bits == '0))
        else $error("error code carries bits");

    // EOB is always the final code of its coefficient.
    a_eob_last: assert property (@(posedge clk) disable iff (!rst_n)
        code_stream.valid && (code_stream.payload.symbol_kind == KIND_EOB)
        |-> code_stream.payload.last_of_item)
        else $error("EOB not marked last");

    // A full zero run never survives into a block start.
    a_zrun_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (zrun_reg == ZRL_COUNT) |-> (pos_reg != '0))
        else $error("zero run pending at block start");
`endif

endmodule
